### hw/rtl/tli_pkg.sv
// tli_pkg: shared constants and the outcome code for the two-line intersection core.
// No dependencies.
package tli_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_BITS       = 48;

    // largest positive Q value; a negative result may reach one more
    localparam logic [OUT_BITS-1:0] LIM_POS = {1'b0, {(OUT_BITS-1){1'b1}}};

    typedef enum logic [1:0] {
        OUT_POINT      = 2'd0,
        OUT_PARALLEL   = 2'd1,
        OUT_COINCIDENT = 2'd2,
        OUT_SATURATED  = 2'd3
    } outcome_t;

endpackage

### hw/rtl/tli_div.sv
// tli_div: fully pipelined restoring divider, one quotient bit per stage, round-to-nearest.
// Standalone; carries a side tag in step with each word.
module tli_div #(
    parameter int NQ = 69,
    parameter int DW = 35,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NQ-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] tag_in,
    output logic          out_valid,
    output logic [NQ:0]   quot,
    output logic [TW-1:0] tag_out
);

    // stage k reads *_w[k]; *_w[k+1] is its register
    logic          v_w  [NQ+1];
    logic [DW-1:0] r_w  [NQ+1];
    logic [NQ-1:0] nq_w [NQ+1];
    logic [DW-1:0] d_w  [NQ+1];
    logic [TW-1:0] t_w  [NQ+1];

    logic          v_reg  [NQ];
    logic [DW-1:0] r_reg  [NQ];
    logic [NQ-1:0] nq_reg [NQ];
    logic [DW-1:0] d_reg  [NQ];
    logic [TW-1:0] t_reg  [NQ];

    logic [DW-1:0] r_next  [NQ];
    logic [NQ-1:0] nq_next [NQ];

    assign v_w[0]  = in_valid;
    assign r_w[0]  = '0;
    assign nq_w[0] = num;
    assign d_w[0]  = den;
    assign t_w[0]  = tag_in;

    for (genvar k = 0; k < NQ; k++) begin : g_stage
        logic [DW:0] trial;
        logic        ge;

        assign trial      = {r_w[k], nq_w[k][NQ-1]};
        assign ge         = trial >= {1'b0, d_w[k]};
        assign r_next[k]  = ge ? DW'(trial - {1'b0, d_w[k]}) : trial[DW-1:0];
        assign nq_next[k] = {nq_w[k][NQ-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[k]  <= r_next[k];
            nq_reg[k] <= nq_next[k];
            d_reg[k]  <= d_w[k];
            t_reg[k]  <= t_w[k];
        end

        assign v_w[k+1]  = v_reg[k];
        assign r_w[k+1]  = r_reg[k];
        assign nq_w[k+1] = nq_reg[k];
        assign d_w[k+1]  = d_reg[k];
        assign t_w[k+1]  = t_reg[k];
    end

    // round: bump when 2*rem >= divisor (ties away from zero on the magnitude)
    logic          rv_reg;
    logic [NQ:0]   q_reg;
    logic [TW-1:0] tag_reg;
    logic          up;

    assign up = {r_w[NQ], 1'b0} >= {1'b0, d_w[NQ]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= v_w[NQ];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= {1'b0, nq_w[NQ]} + (NQ+1)'(up);
        tag_reg <= t_w[NQ];
    end

    assign out_valid = rv_reg;
    assign quot      = q_reg;
    assign tag_out   = tag_reg;

endmodule

### hw/rtl/two_line_intersection_core.sv
// two_line_intersection_core: top level of the line-pair intersection pipeline.
// Depends on tli_pkg and tli_div.
//
//  channel  | handshake           | word
//  ---------+---------------------+-------------------------------------------
//  in       | start & !busy       | line1/line2 start/end x,y (signed ints)
//  out      | done (one cycle)    | outcome, meet_x, meet_y (signed Q31.16)
//
// One word enters per clock; busy is always low. A word passes through the
// front stages, the bit-per-stage dividers and their rounding register, then
// the output register. Reset clears only the valid bits; words in flight
// are dropped. The receiver cannot stall, so nothing backs up.
module two_line_intersection_core import tli_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] line1_start_x,
    input  logic signed [COORD_BITS-1:0] line1_start_y,
    input  logic signed [COORD_BITS-1:0] line1_end_x,
    input  logic signed [COORD_BITS-1:0] line1_end_y,
    input  logic signed [COORD_BITS-1:0] line2_start_x,
    input  logic signed [COORD_BITS-1:0] line2_start_y,
    input  logic signed [COORD_BITS-1:0] line2_end_x,
    input  logic signed [COORD_BITS-1:0] line2_end_y,
    output logic                         done,
    output logic [1:0]                   outcome,
    output logic signed [OUT_BITS-1:0]   meet_x,
    output logic signed [OUT_BITS-1:0]   meet_y
);

    localparam int C    = COORD_BITS;
    localparam int DXW  = C + 1;          // coordinate differences
    localparam int PW   = 2*C + 2;        // first products
    localparam int DENW = 2*C + 3;        // den, t, collinearity, vertical numerator
    localparam int NB   = 3*C + 5;        // full numerator
    localparam int NQ   = NB + FRAC_BITS; // dividend bits after fraction shift
    localparam int QW   = NQ + 1;         // rounded quotient
    localparam int CW   = (QW > OUT_BITS) ? QW : OUT_BITS;
    localparam int TWY  = OUT_BITS + 5;
    localparam int LATENCY = NQ + 8;

    assign busy = 1'b0;

    // ---- stage 1: differences
    logic                   s1_v_reg;
    logic signed [C-1:0]    s1_x1_reg, s1_y1_reg, s1_x3_reg, s1_y3_reg;
    logic signed [DXW-1:0]  s1_dx1_reg, s1_dy1_reg, s1_dx2_reg, s1_dy2_reg;
    logic signed [DXW-1:0]  s1_ax_reg, s1_ay_reg;

    always_ff @(posedge clk)
    begin
        s1_x1_reg  <= line1_start_x;
        s1_y1_reg  <= line1_start_y;
        s1_x3_reg  <= line2_start_x;
        s1_y3_reg  <= line2_start_y;
        s1_dx1_reg <= DXW'(line1_end_x) - DXW'(line1_start_x);
        s1_dy1_reg <= DXW'(line1_end_y) - DXW'(line1_start_y);
        s1_dx2_reg <= DXW'(line2_end_x) - DXW'(line2_start_x);
        s1_dy2_reg <= DXW'(line2_end_y) - DXW'(line2_start_y);
        s1_ax_reg  <= DXW'(line2_start_x) - DXW'(line1_start_x);
        s1_ay_reg  <= DXW'(line2_start_y) - DXW'(line1_start_y);
    end

    // ---- stage 2: cross-product terms
    logic                  s2_v_reg;
    logic signed [PW-1:0]  s2_pa_reg, s2_pb_reg, s2_pc_reg, s2_pd_reg;
    logic signed [PW-1:0]  s2_pe_reg, s2_pf_reg, s2_pg_reg, s2_pi_reg;
    logic                  s2_v1_reg, s2_v2_reg, s2_eqx_reg;
    logic signed [C-1:0]   s2_x1_reg, s2_y1_reg, s2_x3_reg;
    logic signed [DXW-1:0] s2_dx1_reg, s2_dy1_reg, s2_dx2_reg;

    always_ff @(posedge clk)
    begin
        s2_pa_reg  <= PW'(s1_dx1_reg) * PW'(s1_dy2_reg);
        s2_pb_reg  <= PW'(s1_dy1_reg) * PW'(s1_dx2_reg);
        s2_pc_reg  <= PW'(s1_ax_reg)  * PW'(s1_dy2_reg);
        s2_pd_reg  <= PW'(s1_ay_reg)  * PW'(s1_dx2_reg);
        s2_pe_reg  <= PW'(s1_ax_reg)  * PW'(s1_dy1_reg);
        s2_pf_reg  <= PW'(s1_ay_reg)  * PW'(s1_dx1_reg);
        s2_pg_reg  <= PW'(s1_y3_reg)  * PW'(s1_dx2_reg);
        s2_pi_reg  <= PW'(s1_y1_reg)  * PW'(s1_dx1_reg);
        s2_v1_reg  <= (s1_dx1_reg == '0);
        s2_v2_reg  <= (s1_dx2_reg == '0);
        s2_eqx_reg <= (s1_ax_reg == '0);
        s2_x1_reg  <= s1_x1_reg;
        s2_y1_reg  <= s1_y1_reg;
        s2_x3_reg  <= s1_x3_reg;
        s2_dx1_reg <= s1_dx1_reg;
        s2_dy1_reg <= s1_dy1_reg;
        s2_dx2_reg <= s1_dx2_reg;
    end

    // ---- stage 3: den, t, collinearity, vertical-case numerator and exact x
    logic                       s3_v_reg;
    logic signed [DENW-1:0]     s3_den_reg, s3_t_reg, s3_coll_reg, s3_vn_reg;
    logic signed [DXW-1:0]      s3_vden_reg, s3_dx1_reg, s3_dy1_reg;
    logic signed [C-1:0]        s3_x1_reg, s3_y1_reg;
    logic signed [OUT_BITS-1:0] s3_pxe_reg;
    logic                       s3_bothv_reg, s3_vert_reg, s3_eqx_reg;

    always_ff @(posedge clk)
    begin
        s3_den_reg   <= DENW'(s2_pa_reg) - DENW'(s2_pb_reg);
        s3_t_reg     <= DENW'(s2_pc_reg) - DENW'(s2_pd_reg);
        s3_coll_reg  <= DENW'(s2_pe_reg) - DENW'(s2_pf_reg);
        // line one vertical: y3*dx2 + (x1-x3)*dy2; line two: y1*dx1 + (x3-x1)*dy1
        s3_vn_reg    <= s2_v1_reg ? DENW'(s2_pg_reg) - DENW'(s2_pc_reg)
                                  : DENW'(s2_pi_reg) + DENW'(s2_pe_reg);
        s3_vden_reg  <= s2_v1_reg ? s2_dx2_reg : s2_dx1_reg;
        s3_pxe_reg   <= s2_v1_reg ? OUT_BITS'(s2_x1_reg) <<< FRAC_BITS
                                  : OUT_BITS'(s2_x3_reg) <<< FRAC_BITS;
        s3_bothv_reg <= s2_v1_reg & s2_v2_reg;
        s3_vert_reg  <= s2_v1_reg ^ s2_v2_reg;
        s3_eqx_reg   <= s2_eqx_reg;
        s3_x1_reg    <= s2_x1_reg;
        s3_y1_reg    <= s2_y1_reg;
        s3_dx1_reg   <= s2_dx1_reg;
        s3_dy1_reg   <= s2_dy1_reg;
    end

    // ---- stage 4: numerator products, classification
    logic                       s4_v_reg;
    logic signed [NB-1:0]       s4_m1_reg, s4_m2_reg, s4_m3_reg, s4_m4_reg;
    logic signed [DENW-1:0]     s4_den_reg, s4_vn_reg;
    logic signed [DXW-1:0]      s4_vden_reg;
    logic signed [OUT_BITS-1:0] s4_pxe_reg;
    logic                       s4_pt_reg, s4_vert_reg;
    outcome_t                   s4_code_reg;

    always_ff @(posedge clk)
    begin
        s4_m1_reg   <= NB'(s3_x1_reg)  * NB'(s3_den_reg);
        s4_m2_reg   <= NB'(s3_dx1_reg) * NB'(s3_t_reg);
        s4_m3_reg   <= NB'(s3_y1_reg)  * NB'(s3_den_reg);
        s4_m4_reg   <= NB'(s3_dy1_reg) * NB'(s3_t_reg);
        s4_den_reg  <= s3_den_reg;
        s4_vn_reg   <= s3_vn_reg;
        s4_vden_reg <= s3_vden_reg;
        s4_pxe_reg  <= s3_pxe_reg;
        s4_vert_reg <= s3_vert_reg;
        s4_pt_reg   <= !s3_bothv_reg && (s3_vert_reg || s3_den_reg != '0);
        if (s3_bothv_reg)
        begin
            s4_code_reg <= s3_eqx_reg ? OUT_COINCIDENT : OUT_PARALLEL;
        end
        else
        begin
            s4_code_reg <= (s3_coll_reg == '0) ? OUT_COINCIDENT : OUT_PARALLEL;
        end
    end

    // ---- stage 5: numerator sums, divisor select
    logic                       s5_v_reg;
    logic signed [NB-1:0]       s5_nx_reg, s5_ny_reg;
    logic signed [DENW-1:0]     s5_dx_reg, s5_dy_reg;
    logic signed [OUT_BITS-1:0] s5_pxe_reg;
    logic                       s5_pt_reg, s5_vert_reg;
    outcome_t                   s5_code_reg;

    always_ff @(posedge clk)
    begin
        s5_nx_reg   <= s4_m1_reg + s4_m2_reg;
        s5_ny_reg   <= s4_vert_reg ? NB'(s4_vn_reg) : s4_m3_reg + s4_m4_reg;
        s5_dx_reg   <= s4_den_reg;
        s5_dy_reg   <= s4_vert_reg ? DENW'(s4_vden_reg) : s4_den_reg;
        s5_pxe_reg  <= s4_pxe_reg;
        s5_pt_reg   <= s4_pt_reg;
        s5_vert_reg <= s4_vert_reg;
        s5_code_reg <= s4_code_reg;
    end

    // ---- stage 6: sign and magnitude
    logic                       s6_v_reg;
    logic [NB-1:0]              s6_mx_reg, s6_my_reg;
    logic [DENW-1:0]            s6_ddx_reg, s6_ddy_reg;
    logic [TWY-1:0]             s6_tagy_reg;
    logic                       s6_negx_reg;

    always_ff @(posedge clk)
    begin
        s6_mx_reg   <= s5_nx_reg[NB-1] ? NB'(-s5_nx_reg) : NB'(s5_nx_reg);
        s6_my_reg   <= s5_ny_reg[NB-1] ? NB'(-s5_ny_reg) : NB'(s5_ny_reg);
        s6_ddx_reg  <= s5_dx_reg[DENW-1] ? DENW'(-s5_dx_reg) : DENW'(s5_dx_reg);
        s6_ddy_reg  <= s5_dy_reg[DENW-1] ? DENW'(-s5_dy_reg) : DENW'(s5_dy_reg);
        s6_negx_reg <= s5_nx_reg[NB-1] ^ s5_dx_reg[DENW-1];
        s6_tagy_reg <= {s5_pt_reg, s5_code_reg, s5_vert_reg, s5_pxe_reg,
                        s5_ny_reg[NB-1] ^ s5_dy_reg[DENW-1]};
    end

    // valid bits along stages 1..6
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start & ~busy;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
        end
    end

    // ---- dividers: |num| * 2^F / |den|, rounded
    logic           dx_v, dy_v;
    logic [QW-1:0]  qx, qy;
    logic           dx_neg;
    logic [TWY-1:0] dy_tag;

    tli_div #(.NQ(NQ), .DW(DENW), .TW(1)) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s6_v_reg),
        .num      (NQ'(s6_mx_reg) << FRAC_BITS),
        .den      (s6_ddx_reg),
        .tag_in   (s6_negx_reg),
        .out_valid(dx_v),
        .quot     (qx),
        .tag_out  (dx_neg)
    );

    tli_div #(.NQ(NQ), .DW(DENW), .TW(TWY)) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s6_v_reg),
        .num      (NQ'(s6_my_reg) << FRAC_BITS),
        .den      (s6_ddy_reg),
        .tag_in   (s6_tagy_reg),
        .out_valid(dy_v),
        .quot     (qy),
        .tag_out  (dy_tag)
    );

    // ---- final: saturate, apply sign, pick case
    logic                       f_pt, f_vert, f_negy;
    logic [1:0]                 f_code;
    logic signed [OUT_BITS-1:0] f_pxe;
    logic [CW-1:0]              limx, limy, ex, ey, magx, magy;
    logic                       satx, saty;
    logic signed [OUT_BITS-1:0] valx, valy;

    logic                       done_reg;
    logic [1:0]                 outcome_reg;
    logic signed [OUT_BITS-1:0] meet_x_reg, meet_y_reg;
    logic [1:0]                 outcome_next;
    logic signed [OUT_BITS-1:0] meet_x_next, meet_y_next;

    always_comb
    begin
        {f_pt, f_code, f_vert, f_pxe, f_negy} = dy_tag;
        limx = CW'(LIM_POS) + CW'(dx_neg);
        limy = CW'(LIM_POS) + CW'(f_negy);
        ex   = CW'(qx);
        ey   = CW'(qy);
        satx = ex > limx;
        saty = ey > limy;
        magx = satx ? limx : ex;
        magy = saty ? limy : ey;
        valx = dx_neg ? -magx[OUT_BITS-1:0] : magx[OUT_BITS-1:0];
        valy = f_negy ? -magy[OUT_BITS-1:0] : magy[OUT_BITS-1:0];
        if (f_pt)
        begin
            meet_x_next  = f_vert ? f_pxe : valx;
            meet_y_next  = valy;
            outcome_next = (saty || (!f_vert && satx)) ? OUT_SATURATED : OUT_POINT;
        end
        else
        begin
            meet_x_next  = '0;
            meet_y_next  = '0;
            outcome_next = f_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dy_v & dx_v;
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
        meet_x_reg  <= meet_x_next;
        meet_y_reg  <= meet_y_next;
    end

    assign done    = done_reg;
    assign outcome = outcome_reg;
    assign meet_x  = meet_x_reg;
    assign meet_y  = meet_y_reg;

endmodule

### hw/rtl/tli_chk.sv
// tli_chk: port-level checks on two_line_intersection_core, plus its bind.
// Depends on tli_pkg.
module tli_chk import tli_pkg::*; #(
    parameter int LATENCY = 77
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [1:0]                 outcome,
    input logic signed [OUT_BITS-1:0] meet_x,
    input logic signed [OUT_BITS-1:0] meet_y
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("word lost in pipeline");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without word");

    a_zero_when_no_point: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (outcome == OUT_PARALLEL || outcome == OUT_COINCIDENT))
            |-> (meet_x == '0 && meet_y == '0))
        else $error("nonzero point for parallel or coincident");

endmodule

bind two_line_intersection_core tli_chk #(.LATENCY(LATENCY)) u_tli_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .outcome(outcome),
    .meet_x (meet_x),
    .meet_y (meet_y)
);
